>>> rtl/dnsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and the case-folding function of the DNS name decompressor.
// No dependencies.
package dnsd_pkg;

	// item action codes
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_END   = 2'd1;
	localparam logic [1:0] ST_JUMPS = 2'd2;
	localparam logic [1:0] ST_LONG  = 2'd3;

	// configuration register indexes
	localparam logic REG_JUMP_LIMIT     = 1'b0;
	localparam logic REG_NAME_LEN_LIMIT = 1'b1;

	localparam logic [3:0] JUMP_LIMIT_RST    = 4'd5;
	localparam logic [7:0] NAME_LEN_LIM_RST  = 8'd255;

	localparam logic [7:0] PTR_MARK  = 8'hC0;
	localparam logic [7:0] DOT_CHAR  = 8'h2E;
	localparam int         PTR_W     = 14;
	// read position: covers any pointer target and a store of up to 16384 bytes
	localparam int         POS_W     = PTR_W + 1;
	localparam int         MAX_WORDS = 32;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/dnsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module dnsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/dns_name_decompressor.sv
`timescale 1ns / 1ps
`default_nettype none
// DNS name decompressor top level: message store, label walker, word packer.
// Depends on dnsd_pkg and dnsd_ram.
//
// After reset the block zeroes the message store with busy high;
// configuration writes are taken meanwhile. A write item (action 0) returns
// nothing. A decode item walks the name in the store through its single read
// port: each length byte is checked in a head and a length step, a compression
// pointer adds a step for its low byte, label characters are read one by one,
// and a flush step sends the final word.
// Result words appear for one cycle each on result_valid and cannot be held
// off; the final word has last set and carries status and next_offset.
module dns_name_decompressor
	import dnsd_pkg::*;
#(
	parameter int STORE_BYTES    = 512,
	parameter int CHARS_PER_WORD = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	// item channel
	input  wire         start,
	output logic        busy,
	input  wire         action,
	input  wire  [8:0]  offset,
	input  wire  [7:0]  byte_in,
	// configuration channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [7:0]  cfg_data,
	// results
	output logic        result_valid,
	output logic [63:0] chars,
	output logic [3:0]  char_count,
	output logic        last,
	output logic [1:0]  status,
	output logic [9:0]  next_offset
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam logic [POS_W:0] STORE_END = (POS_W + 1)'(STORE_BYTES);
	localparam logic [3:0]     CPW       = 4'(CHARS_PER_WORD);
	localparam logic [9:0]     NAME_CAP  = 10'(MAX_WORDS * CHARS_PER_WORD);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HEAD, S_LEN, S_PTR_LO, S_LABEL, S_FLUSH
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic [3:0]       jump_limit_q;
	logic [7:0]       name_len_lim_q;
	logic [POS_W-1:0] pos_q;
	logic [9:0]       next_q;
	logic [4:0]       jumps_q;
	logic             jumped_q;
	logic             first_q;
	logic [8:0]       n_q;
	logic [7:0]       rem_q;
	logic [5:0]       ptr_hi_q;
	logic [1:0]       stat_q;
	logic             char_pend_s1;
	logic [7:0][7:0]  wbuf_q;
	logic [3:0]       wcnt_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [7:0]       ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [7:0]       ram_rdata;

	logic             accept;
	logic             is_ptr;
	logic [POS_W:0]   pos_x;
	logic [POS_W:0]   pos_p1;
	logic [POS_W:0]   label_end;
	logic [9:0]       name_need;
	logic [9:0]       limit;
	logic             app_vld;
	logic [7:0]       app_char;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	assign is_ptr    = ((ram_rdata & PTR_MARK) == PTR_MARK);
	assign pos_x     = {1'b0, pos_q};
	assign pos_p1    = pos_x + (POS_W + 1)'(1);
	assign label_end = pos_p1 + (POS_W + 1)'(ram_rdata);
	assign name_need = 10'(n_q) + (first_q ? 10'd0 : 10'd1) + 10'(ram_rdata);
	assign limit     = (10'(name_len_lim_q) > NAME_CAP) ? NAME_CAP : 10'(name_len_lim_q);

	// store write: clearing pass or a write item
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 8'd0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (accept && action == ACT_WRITE
				&& (POS_W + 1)'(offset) < STORE_END) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(offset);
			ram_wdata = byte_in;
		end
	end

	// pointer low byte sits right after the high byte; other reads use pos
	assign ram_raddr = (state_q == S_LEN) ? AW'(pos_p1) : AW'(pos_q);

	dnsd_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// character into the packer: separator from the length step, label bytes
	// in the cycle after their read
	always_comb begin
		app_vld  = 1'b0;
		app_char = DOT_CHAR;
		if (char_pend_s1) begin
			app_vld  = 1'b1;
			app_char = fold_case(ram_rdata);
		end else if (state_q == S_LEN && !is_ptr && ram_rdata != 8'd0
				&& label_end <= STORE_END && name_need <= limit && !first_q) begin
			app_vld = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			jump_limit_q   <= JUMP_LIMIT_RST;
			name_len_lim_q <= NAME_LEN_LIM_RST;
			pos_q          <= '0;
			next_q         <= '0;
			jumps_q        <= '0;
			jumped_q       <= 1'b0;
			first_q        <= 1'b1;
			n_q            <= '0;
			rem_q          <= '0;
			ptr_hi_q       <= '0;
			stat_q         <= ST_OK;
			char_pend_s1   <= 1'b0;
			wbuf_q         <= '0;
			wcnt_q         <= '0;
			result_valid   <= 1'b0;
			chars          <= '0;
			char_count     <= '0;
			last           <= 1'b0;
			status         <= ST_OK;
			next_offset    <= '0;
		end else begin
			result_valid <= 1'b0;
			char_pend_s1 <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_JUMP_LIMIT:     jump_limit_q   <= cfg_data[3:0];
					REG_NAME_LEN_LIMIT: name_len_lim_q <= cfg_data;
					default: ;
				endcase
			end

			if (app_vld) begin
				if (wcnt_q == CPW) begin
					result_valid <= 1'b1;
					chars        <= wbuf_q;
					char_count   <= CPW;
					last         <= 1'b0;
					status       <= ST_OK;
					next_offset  <= '0;
					wbuf_q       <= {56'd0, app_char};
					wcnt_q       <= 4'd1;
				end else begin
					wbuf_q[wcnt_q[2:0]] <= app_char;
					wcnt_q              <= wcnt_q + 4'd1;
				end
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(STORE_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && action == ACT_DECODE) begin
						pos_q    <= POS_W'(offset);
						next_q   <= 10'(offset);
						jumps_q  <= '0;
						jumped_q <= 1'b0;
						first_q  <= 1'b1;
						n_q      <= '0;
						stat_q   <= ST_OK;
						wbuf_q   <= '0;
						wcnt_q   <= '0;
						state_q  <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (jumps_q > {1'b0, jump_limit_q}) begin
						stat_q  <= ST_JUMPS;
						state_q <= S_FLUSH;
					end else if (pos_x >= STORE_END) begin
						stat_q  <= ST_END;
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					if (is_ptr) begin
						if (!jumped_q) begin
							next_q <= 10'(pos_x + (POS_W + 1)'(2));
						end
						ptr_hi_q <= ram_rdata[5:0];
						if (pos_p1 >= STORE_END) begin
							stat_q  <= ST_END;
							state_q <= S_FLUSH;
						end else begin
							state_q <= S_PTR_LO;
						end
					end else if (ram_rdata == 8'd0) begin
						if (!jumped_q) begin
							next_q <= 10'(pos_p1);
						end
						state_q <= S_FLUSH;
					end else if (label_end > STORE_END) begin
						stat_q  <= ST_END;
						state_q <= S_FLUSH;
					end else if (name_need > limit) begin
						stat_q  <= ST_LONG;
						state_q <= S_FLUSH;
					end else begin
						n_q     <= name_need[8:0];
						first_q <= 1'b0;
						pos_q   <= pos_p1[POS_W-1:0];
						rem_q   <= ram_rdata;
						state_q <= S_LABEL;
					end
				end
				S_PTR_LO: begin
					pos_q    <= POS_W'({ptr_hi_q, ram_rdata});
					jumped_q <= 1'b1;
					jumps_q  <= jumps_q + 5'd1;
					state_q  <= S_HEAD;
				end
				S_LABEL: begin
					char_pend_s1 <= 1'b1;
					pos_q        <= pos_q + POS_W'(1);
					rem_q        <= rem_q - 8'd1;
					if (rem_q == 8'd1) begin
						state_q <= S_HEAD;
					end
				end
				S_FLUSH: begin
					result_valid <= 1'b1;
					chars        <= wbuf_q;
					char_count   <= wcnt_q;
					last         <= 1'b1;
					status       <= stat_q;
					next_offset  <= next_q;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// only the final word of a name carries status and position
	a_mid_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> status == ST_OK && next_offset == 10'd0)
		else $error("status or next_offset set on a non-final word");

	// a word that is not the last is always full
	a_mid_word_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> char_count == CPW)
		else $error("non-final word not full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> char_count <= CPW)
		else $error("char_count above word size");

	// a write item yields no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == ACT_WRITE |=> !result_valid)
		else $error("result after a write item");

endmodule
`default_nettype wire

>>> tb/tb_dns_name_decompressor.sv
`timescale 1ns / 1ps
// Self-checking testbench for dns_name_decompressor: fills the message store, decodes names
// and checks every result word against an in-bench model of the label walk.
// Depends on dnsd_pkg and the dns_name_decompressor RTL.
module tb_dns_name_decompressor;
	import dnsd_pkg::*;

	localparam int STORE_SIZE  = 512;
	localparam int WORD_CHARS  = 8;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [63:0] chars;
		logic [3:0]  count;
		logic        last;
		logic [1:0]  status;
		logic [9:0]  next_pos;
	} name_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [8:0]  offset;
	logic [7:0]  byte_in;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	logic        result_valid;
	logic [63:0] chars;
	logic [3:0]  char_count;
	logic        last;
	logic [1:0]  status;
	logic [9:0]  next_offset;

	// model state
	logic [7:0]  store_copy [STORE_SIZE];
	logic [3:0]  jump_lim_copy;
	logic [7:0]  name_lim_copy;
	name_word_t  pending_words [$];

	int          bad_words;
	int          words_checked;
	int          items_issued;
	int          decodes_issued;
	int          cycles;
	bit          gaps_on;
	int          name_cursor;
	int          name_starts [$];

	dns_name_decompressor i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.offset      (offset),
		.byte_in     (byte_in),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.chars       (chars),
		.char_count  (char_count),
		.last        (last),
		.status      (status),
		.next_offset (next_offset)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending", cycles,
				pending_words.size());
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] lower_ascii(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
	endfunction

	// walk the name at name_addr in the model store and queue its result words
	task automatic predict_name_words(input logic [8:0] name_addr);
		logic [7:0] name_buf [256];
		logic [7:0] b;
		logic [1:0] st;
		int pos, nxt, jumps, n, limit, words, k, i, idx;
		bit jumped, first_label;
		name_word_t w;
		limit = name_lim_copy;
		if (limit > MAX_WORDS * WORD_CHARS) limit = MAX_WORDS * WORD_CHARS;
		pos = name_addr;
		nxt = name_addr;
		jumps = 0;
		n = 0;
		st = ST_OK;
		jumped = 1'b0;
		first_label = 1'b1;
		forever begin
			if (jumps > jump_lim_copy) begin
				st = ST_JUMPS;
				break;
			end
			if (pos >= STORE_SIZE) begin
				st = ST_END;
				break;
			end
			b = store_copy[pos];
			if ((b & PTR_MARK) == PTR_MARK) begin
				if (!jumped) nxt = pos + 2;
				if (pos + 1 >= STORE_SIZE) begin
					st = ST_END;
					break;
				end
				pos = {b[5:0], store_copy[pos + 1]};
				jumped = 1'b1;
				jumps++;
				continue;
			end
			pos++;
			if (b == 8'h00) begin
				if (!jumped) nxt = pos;
				break;
			end
			if (pos + b > STORE_SIZE) begin
				st = ST_END;
				break;
			end
			if (n + (first_label ? 0 : 1) + b > limit) begin
				st = ST_LONG;
				break;
			end
			if (!first_label) begin
				name_buf[n] = DOT_CHAR;
				n++;
			end
			for (i = 0; i < b; i++) begin
				name_buf[n] = lower_ascii(store_copy[pos + i]);
				n++;
			end
			pos += b;
			first_label = 1'b0;
		end
		words = (n == 0) ? 1 : (n + WORD_CHARS - 1) / WORD_CHARS;
		for (k = 0; k < words; k++) begin
			w = '0;
			for (i = 0; i < WORD_CHARS; i++) begin
				idx = k * WORD_CHARS + i;
				if (idx < n) begin
					w.chars[8 * i +: 8] = name_buf[idx];
					w.count++;
				end
			end
			if (k == words - 1) begin
				w.last = 1'b1;
				w.status = st;
				w.next_pos = nxt[9:0];
			end
			pending_words = {pending_words, w};
		end
	endtask

	task automatic report_mismatch(input string what, input name_word_t e, input name_word_t g);
		bad_words++;
		if (bad_words <= 10) begin
			$display("%0t %s: exp chars=%h cnt=%0d last=%b st=%0d next=%0d", $time, what,
				e.chars, e.count, e.last, e.status, e.next_pos);
			$display("%0t %s: got chars=%h cnt=%0d last=%b st=%0d next=%0d", $time, what,
				g.chars, g.count, g.last, g.status, g.next_pos);
		end
	endtask

	always @(posedge clk) begin : check_words
		name_word_t got_w;
		name_word_t exp_w;
		if (arst_n && result_valid) begin
			got_w = {chars, char_count, last, status, next_offset};
			words_checked++;
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", '0, got_w);
			end else begin
				exp_w = pending_words.pop_front();
				if (got_w.chars !== exp_w.chars || got_w.count !== exp_w.count ||
						got_w.last !== exp_w.last || got_w.status !== exp_w.status ||
						got_w.next_pos !== exp_w.next_pos) begin
					report_mismatch("word mismatch", exp_w, got_w);
				end
			end
		end
	end

	// called at a falling edge; leaves start high so back-to-back items need no gap
	task automatic issue_item(input logic act, input logic [8:0] addr, input logic [7:0] data);
		int gap;
		if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
		gap = gaps_on ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		action  <= act;
		offset  <= addr;
		byte_in <= data;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_issued++;
		if (act == ACT_WRITE) begin
			store_copy[addr] = data;
		end else begin
			decodes_issued++;
			predict_name_words(addr);
		end
		@(negedge clk);
	endtask

	task automatic store_byte(input logic [8:0] addr, input logic [7:0] data);
		issue_item(ACT_WRITE, addr, data);
	endtask

	task automatic decode_at(input logic [8:0] addr);
		issue_item(ACT_DECODE, addr, 8'($urandom_range(0, 255)));
	endtask

	task automatic cfg_write(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_JUMP_LIMIT) jump_lim_copy = val[3:0];
		else name_lim_copy = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold items off until every expected word is back and the block is idle
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0 || busy) @(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic test_empty_names();
		decode_at(9'd0);
		decode_at(9'd511);
	endtask

	task automatic test_labels_and_case();
		store_byte(9'h100, 8'd3);
		store_byte(9'h101, "A");
		store_byte(9'h102, "Z");
		store_byte(9'h103, 8'hFF);
		store_byte(9'h104, 8'd2);
		store_byte(9'h105, "@");
		store_byte(9'h106, "[");
		store_byte(9'h107, 8'h00);
		decode_at(9'h100);
	endtask

	task automatic test_pointers();
		store_byte(9'h1F0, 8'd1);
		store_byte(9'h1F1, "W");
		store_byte(9'h1F2, PTR_MARK | 8'h01);
		store_byte(9'h1F3, 8'h00);
		decode_at(9'h1F0);
		decode_at(9'h1F2);
	endtask

	task automatic test_store_end();
		// pointer in the last byte has no low byte
		store_byte(9'h1FF, PTR_MARK);
		decode_at(9'h1FF);
		// label runs off the end
		store_byte(9'h1FE, 8'd5);
		decode_at(9'h1FE);
		// pointer targets beyond the store
		store_byte(9'h010, PTR_MARK | 8'h02);
		store_byte(9'h011, 8'h00);
		store_byte(9'h012, 8'hFF);
		store_byte(9'h013, 8'hFF);
		decode_at(9'h010);
		decode_at(9'h012);
	endtask

	task automatic test_jump_limit();
		store_byte(9'h020, PTR_MARK);
		store_byte(9'h021, 8'h20);
		decode_at(9'h020);
		wait_idle();
		cfg_write(REG_JUMP_LIMIT, 8'd0);
		decode_at(9'h1F0);
		decode_at(9'h100);
		wait_idle();
		cfg_write(REG_JUMP_LIMIT, 8'd15);
		decode_at(9'h020);
		wait_idle();
		cfg_write(REG_JUMP_LIMIT, {4'd0, JUMP_LIMIT_RST});
	endtask

	// length bytes 0x40..0xBF are plain lengths; 64 + 1 + 190 fills the 255 character cap
	task automatic test_wide_labels();
		store_byte(9'h030, 8'h40);
		store_byte(9'h071, 8'hBE);
		store_byte(9'h140, 8'hBF);
		decode_at(9'h030);
		decode_at(9'h140);
	endtask

	task automatic test_length_limit();
		wait_idle();
		cfg_write(REG_NAME_LEN_LIMIT, 8'd1);
		decode_at(9'h100);
		decode_at(9'h1F0);
		wait_idle();
		cfg_write(REG_NAME_LEN_LIMIT, 8'd254);
		decode_at(9'h030);
		wait_idle();
		cfg_write(REG_NAME_LEN_LIMIT, NAME_LEN_LIM_RST);
	endtask

	// writes a name at the cursor, ending in a zero or a pointer to an earlier recorded position, possibly in this name
	task automatic build_name();
		int n_lab, total, i, j, pos, tgt;
		int lab_len [4];
		logic [7:0] ch;
		n_lab = $urandom_range(0, 3);
		total = 2;
		for (i = 0; i < n_lab; i++) begin
			lab_len[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
			total += lab_len[i] + 1;
		end
		if (name_cursor + total > STORE_SIZE) begin
			name_cursor = $urandom_range(0, 63);
			name_starts.delete();
		end
		pos = name_cursor;
		for (i = 0; i < n_lab; i++) begin
			name_starts = {name_starts, pos};
			store_byte(9'(pos), 8'(lab_len[i]));
			pos++;
			for (j = 0; j < lab_len[i]; j++) begin
				case ($urandom_range(0, 3))
					0: ch = 8'h41 + 8'($urandom_range(0, 25));
					1: ch = 8'h61 + 8'($urandom_range(0, 25));
					2: ch = ($urandom_range(0, 1) != 0) ? 8'h2D : 8'h30 + 8'($urandom_range(0, 9));
					default: ch = 8'($urandom_range(0, 255));
				endcase
				store_byte(9'(pos), ch);
				pos++;
			end
		end
		if (name_starts.size() != 0 && $urandom_range(0, 2) == 0) begin
			tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
			name_starts = {name_starts, pos};
			store_byte(9'(pos), PTR_MARK | {7'd0, tgt[8]});
			store_byte(9'(pos + 1), tgt[7:0]);
			pos += 2;
		end else begin
			name_starts = {name_starts, pos};
			store_byte(9'(pos), 8'h00);
			pos++;
		end
		name_cursor = pos;
	endtask

	task automatic run_random_phase(input logic [3:0] jl, input logic [7:0] nl, input int n_items);
		int item_goal, r;
		wait_idle();
		cfg_write(REG_JUMP_LIMIT, {4'd0, jl});
		cfg_write(REG_NAME_LEN_LIMIT, nl);
		item_goal = items_issued + n_items;
		while (items_issued < item_goal) begin
			r = $urandom_range(0, 9);
			if (r == 0) store_byte(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
			else if (r == 1) decode_at(9'($urandom_range(0, 511)));
			else if (r < 5 || name_starts.size() == 0) build_name();
			else decode_at(9'(name_starts[$urandom_range(0, name_starts.size() - 1)]));
		end
		wait_idle();
	endtask

	task automatic test_random();
		name_cursor = 9'h150;
		run_random_phase(JUMP_LIMIT_RST, NAME_LEN_LIM_RST, 12);
		run_random_phase(4'd0, 8'($urandom_range(8, 40)), 12);
		run_random_phase(4'd15, 8'd255, 12);
		run_random_phase(4'($urandom_range(0, 15)), 8'($urandom_range(1, 255)), 12);
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		action    = ACT_WRITE;
		offset    = '0;
		byte_in   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_JUMP_LIMIT;
		cfg_data  = '0;
		gaps_on   = 1'b1;
		foreach (store_copy[i]) store_copy[i] = 8'h00;
		jump_lim_copy = JUMP_LIMIT_RST;
		name_lim_copy = NAME_LEN_LIM_RST;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		// taken while the store is still being cleared
		cfg_write(REG_JUMP_LIMIT, {4'd0, JUMP_LIMIT_RST});
		cfg_write(REG_NAME_LEN_LIMIT, NAME_LEN_LIM_RST);

		test_empty_names();
		test_labels_and_case();
		test_pointers();
		test_store_end();
		test_jump_limit();
		test_wide_labels();
		test_length_limit();
		test_random();

		wait_idle();
		repeat (16) @(negedge clk);
		if (pending_words.size() != 0) begin
			report_mismatch("missing word", pending_words[0], '0);
		end
		$display("Summary: %0d items (%0d decodes), %0d result words checked, %0d mismatches",
			items_issued, decodes_issued, words_checked, bad_words);
		$display("Covered empty names, pointers, store end, jump limits 0..15, name limits 1..255");
		if (bad_words == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
